[hw/rtl/qpht_pkg.sv]
// Package for the quadratic-probe hash table: widths, status and action codes,
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package qpht_pkg;

  localparam int TableDepth = 256;
  localparam int SlotW      = $clog2(TableDepth);
  localparam int SizeW      = SlotW + 1;
  localparam int KeyW       = 31;
  localparam int PayW       = 64;
  localparam int DivSteps   = KeyW;
  localparam int DivCntW    = $clog2(DivSteps);

  localparam logic [SizeW-1:0] SizeReset = SizeW'(TableDepth);

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_DELETED   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DELETE = 1'b1
  } action_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // latch a new item and clear the divider
    logic div_en;       // one restoring-division step
    logic probe_start;  // reset probe sequence and check stage
    logic probe_en;     // issue the next probe
    logic finish;       // update the table and write the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;   // current division step is the final one
    logic found;      // checked slot satisfies the operation
    logic exhausted;  // last probe checked with no match
    logic out_free;   // result register can take a new result
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/qpht_req_if.sv]
// Request channel interface: valid/ready plus action, key and payload.
// Depends on qpht_pkg.
`default_nettype none

interface qpht_req_if;
  import qpht_pkg::*;

  logic              valid;
  logic              ready;
  action_t           action;
  logic [KeyW-1:0]   key;
  logic [PayW-1:0]   payload;

  modport source (output valid, action, key, payload, input ready);
  modport sink   (input valid, action, key, payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/qpht_rsp_if.sv]
// Response channel interface: valid/ready plus status and slot.
// Depends on qpht_pkg.
`default_nettype none

interface qpht_rsp_if;
  import qpht_pkg::*;

  logic              valid;
  logic              ready;
  status_t           status;
  logic [SlotW-1:0]  slot;

  modport source (output valid, status, slot, input ready);
  modport sink   (input valid, status, slot, output ready);
endinterface

`default_nettype wire

[hw/rtl/qpht_ctrl.sv]
// Controller state machine: accept, divide for the home slot, probe, finish.
// Depends on qpht_pkg.
`default_nettype none

module qpht_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  qpht_pkg::sts_t sts,
  output qpht_pkg::cmd_t cmd
);
  import qpht_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_PROBE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        if (sts.div_last) begin
          cmd.probe_start = 1'b1;
          state_next      = S_PROBE;
        end
      end
      S_PROBE: begin
        // Stop issuing once a decision is made so the check stage holds it.
        if (sts.found || sts.exhausted) begin
          state_next = S_DONE;
        end else begin
          cmd.probe_en = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/qpht_dp.sv]
// Datapath: size register, serial divider for the home slot, incremental
// quadratic probe generator, key/payload memories, occupied bits, result register.
// Depends on qpht_pkg.
`default_nettype none

module qpht_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  qpht_pkg::cmd_t             cmd,
  output qpht_pkg::sts_t             sts,
  input  logic                       cfg_we,
  input  logic [qpht_pkg::SizeW-1:0] cfg_wdata,
  input  qpht_pkg::action_t          in_action,
  input  logic [qpht_pkg::KeyW-1:0]  in_key,
  input  logic [qpht_pkg::PayW-1:0]  in_payload,
  input  logic                       out_ready,
  output logic                       out_valid,
  output qpht_pkg::status_t          out_status,
  output logic [qpht_pkg::SlotW-1:0] out_slot
);
  import qpht_pkg::*;

  logic [SizeW-1:0]   table_size;
  logic [SizeW-1:0]   size;

  action_t            act;
  logic [KeyW-1:0]    key_q;
  logic [PayW-1:0]    pay_q;
  logic [KeyW-1:0]    kshift;
  logic [SizeW-1:0]   rem;
  logic [DivCntW-1:0] divcnt;

  logic [SizeW-1:0]   q;
  logic [SizeW-1:0]   d;
  logic [SizeW-1:0]   pcnt;

  logic               chk_valid;
  logic               chk_last;
  logic [SlotW-1:0]   chk_slot;
  logic [KeyW-1:0]    key_rd;

  logic [KeyW-1:0]    slot_keys     [TableDepth];
  logic [PayW-1:0]    slot_payloads [TableDepth];
  logic [TableDepth-1:0] occ;

  logic [SizeW-1:0]   div_t;
  logic [SizeW:0]     slot_sum;
  logic [SizeW:0]     q_sum;
  logic [SizeW:0]     d_sum;
  logic [SlotW-1:0]   probe_addr;
  logic [SizeW-1:0]   q_next;
  logic [SizeW-1:0]   d_next;
  logic               issue;
  logic               commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SizeReset;
    end else if (cfg_we) begin
      table_size <= cfg_wdata;
    end
  end

  // Zero behaves as one slot; anything beyond the depth saturates.
  always_comb begin
    if (table_size == '0) begin
      size = SizeW'(1);
    end else if (table_size > SizeW'(TableDepth)) begin
      size = SizeW'(TableDepth);
    end else begin
      size = table_size;
    end
  end

  // Restoring division, one key bit per cycle; rem ends as key mod size.
  // rem stays below size, so its top bit is zero before the shift.
  assign div_t = {rem[SizeW-2:0], kshift[KeyW-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act    <= in_action;
      key_q  <= in_key;
      pay_q  <= in_payload;
      kshift <= in_key;
      rem    <= '0;
      divcnt <= '0;
    end else if (cmd.div_en) begin
      rem    <= (div_t >= size) ? div_t - size : div_t;
      kshift <= {kshift[KeyW-2:0], 1'b0};
      divcnt <= divcnt + DivCntW'(1);
    end
  end

  // q tracks p*p mod size and d tracks (2p+1) mod size, so each probe needs
  // only adds with a single conditional subtract.
  assign slot_sum   = {1'b0, rem} + {1'b0, q};
  assign q_sum      = {1'b0, q} + {1'b0, d};
  assign d_sum      = {1'b0, d} + (SizeW+1)'(2);
  assign probe_addr = (slot_sum >= {1'b0, size}) ? SlotW'(slot_sum - {1'b0, size})
                                                 : SlotW'(slot_sum);
  assign q_next     = (q_sum >= {1'b0, size}) ? SizeW'(q_sum - {1'b0, size})
                                              : SizeW'(q_sum);
  assign d_next     = (d_sum >= {1'b0, size}) ? SizeW'(d_sum - {1'b0, size})
                                              : SizeW'(d_sum);
  assign issue      = cmd.probe_en && (pcnt < size);

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else if (cmd.probe_start) begin
      chk_valid <= 1'b0;
    end else if (cmd.probe_en) begin
      chk_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_start) begin
      q    <= '0;
      d    <= (size == SizeW'(1)) ? '0 : SizeW'(1);
      pcnt <= '0;
    end else if (issue) begin
      q        <= q_next;
      d        <= d_next;
      pcnt     <= pcnt + SizeW'(1);
      chk_slot <= probe_addr;
      chk_last <= (pcnt == size - SizeW'(1));
    end
  end

  assign commit = cmd.finish && sts.found;

  always_ff @(posedge clk) begin
    if (issue) begin
      key_rd <= slot_keys[probe_addr];
    end
    if (commit && act == ACT_INSERT) begin
      slot_keys[chk_slot]     <= key_q;
      slot_payloads[chk_slot] <= pay_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (commit) begin
      occ[chk_slot] <= (act == ACT_INSERT);
    end
  end

  always_comb begin
    sts.div_last = (divcnt == DivCntW'(DivSteps - 1));
    if (act == ACT_INSERT) begin
      sts.found = chk_valid && !occ[chk_slot];
    end else begin
      sts.found = chk_valid && occ[chk_slot] && (key_rd == key_q);
    end
    sts.exhausted = chk_valid && chk_last && !sts.found;
    sts.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (sts.found) begin
        out_status <= (act == ACT_INSERT) ? ST_INSERTED : ST_DELETED;
        out_slot   <= chk_slot;
      end else begin
        out_status <= (act == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
        out_slot   <= '0;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/quadratic_probe_hash_table_top.sv]
// Top level of the quadratic-probe hash table: controller plus datapath.
// Depends on qpht_pkg, qpht_req_if, qpht_rsp_if, qpht_ctrl, qpht_dp.
//
//   Port      Dir  Handshake        Contents
//   req       in   valid/ready      action, key, payload
//   rsp       out  valid/ready      status, slot
//   cfg_*     in   write enable     table_size (9 bits)
//
// An item passes an accept step, serial division for the home slot, up to one
// probe per active slot (one key-memory read per probe, checked in the next
// cycle) and a finish step.
// Reset clears all occupied bits at once and sets table_size to 256.
// The result waits in an output register; a new item is accepted meanwhile,
// and its finish cycle waits until that register is free.
`default_nettype none

module quadratic_probe_hash_table_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [qpht_pkg::SizeW-1:0] cfg_wdata,
  qpht_req_if.sink                   req,
  qpht_rsp_if.source                 rsp
);
  import qpht_pkg::*;

  cmd_t cmd;
  sts_t sts;

  qpht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qpht_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_action  (req.action),
    .in_key     (req.key),
    .in_payload (req.payload),
    .out_ready  (rsp.ready),
    .out_valid  (rsp.valid),
    .out_status (rsp.status),
    .out_slot   (rsp.slot)
  );

  // Only one item is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while an item is in work");

  // A result appears only from a finish command.
  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(cmd.finish))
    else $error("result valid without a finish");

  // Failed operations report slot zero.
  a_fail_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == ST_FULL || rsp.status == ST_NOT_FOUND))
      |-> (rsp.slot == '0))
    else $error("nonzero slot on failed operation");

  // A decision never comes without a checked probe.
  a_decision_checked: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (sts.found || sts.exhausted))
    else $error("finish without a probe decision");

endmodule

`default_nettype wire

[tb/quadratic_probe_hash_table_top_tb.sv]
// Self-checking testbench for quadratic_probe_hash_table_top: a directed table, then random
// insert/delete traffic across several table sizes, checked against fixed results or a local table model.
// Depends on qpht_pkg, qpht_req_if, qpht_rsp_if and the RTL of the top level.
`default_nettype none

module quadratic_probe_hash_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qpht_pkg::*;

  typedef struct {
    status_t          status;
    logic [SlotW-1:0] slot;
  } outcome_t;

  typedef enum logic {ROW_ITEM, ROW_SIZE} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    action_t          act;
    logic [KeyW-1:0]  key;
    logic [PayW-1:0]  pay;
    logic [SizeW-1:0] size;
    bit               typed;
    outcome_t         want;
  } dir_row_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [SizeW-1:0] cfg_wdata;

  qpht_req_if req_ch ();
  qpht_rsp_if rsp_ch ();

  quadratic_probe_hash_table_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Local copy of the table and its size register.
  logic [KeyW-1:0]  slot_key_q  [TableDepth];
  logic [PayW-1:0]  slot_pay_q  [TableDepth];
  bit               slot_used_q [TableDepth];
  logic [SizeW-1:0] table_size_q;

  outcome_t expected_outcomes[$];
  dir_row_t dir_rows[$];
  int       mismatch_count;
  int       send_idle_pct;
  int       rsp_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(60_000_000);
    $display("quadratic_probe_hash_table_top verification failed");
    $finish;
  end

  // Size zero behaves as one slot, sizes above the depth as the full depth.
  function automatic int unsigned active_slots();
    if (table_size_q == '0) return 1;
    if (table_size_q > TableDepth) return TableDepth;
    return table_size_q;
  endfunction

  function automatic outcome_t hash_table_apply(input action_t act, input logic [KeyW-1:0] k,
                                                input logic [PayW-1:0] pay);
    outcome_t    r;
    int unsigned size;
    int unsigned home;
    int unsigned s;
    int unsigned p;
    bit          done;
    size = active_slots();
    home = k % size;
    done = 1'b0;
    r.status = (act == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
    r.slot = '0;
    for (p = 0; p < size && !done; p++) begin
      s = (home + (p * p) % size) % size;
      if (act == ACT_INSERT) begin
        if (!slot_used_q[s]) begin
          slot_key_q[s] = k;
          slot_pay_q[s] = pay;
          slot_used_q[s] = 1'b1;
          r.status = ST_INSERTED;
          r.slot = SlotW'(s);
          done = 1'b1;
        end
      end else if (slot_used_q[s] && slot_key_q[s] == k) begin
        slot_used_q[s] = 1'b0;
        r.status = ST_DELETED;
        r.slot = SlotW'(s);
        done = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic dir_row_t typed_row(input action_t act, input logic [KeyW-1:0] k,
                                         input logic [PayW-1:0] pay, input status_t st,
                                         input logic [SlotW-1:0] slot);
    dir_row_t r;
    r.kind = ROW_ITEM;
    r.act = act;
    r.key = k;
    r.pay = pay;
    r.size = '0;
    r.typed = 1'b1;
    r.want.status = st;
    r.want.slot = slot;
    return r;
  endfunction

  function automatic dir_row_t pred_row(input action_t act, input logic [KeyW-1:0] k,
                                        input logic [PayW-1:0] pay);
    dir_row_t r;
    r = typed_row(act, k, pay, ST_INSERTED, '0);
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t size_row(input logic [SizeW-1:0] size);
    dir_row_t r;
    r = pred_row(ACT_INSERT, '0, '0);
    r.kind = ROW_SIZE;
    r.size = size;
    return r;
  endfunction

  // Presents one request, waits for its transfer and records what it should produce.
  task automatic send_item(input action_t act, input logic [KeyW-1:0] k,
                           input logic [PayW-1:0] pay, input bit typed, input outcome_t want);
    outcome_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.action  <= act;
    req_ch.key     <= k;
    req_ch.payload <= pay;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = hash_table_apply(act, k, pay);
    if (typed) expected_outcomes.push_back(want);
    else expected_outcomes.push_back(predicted);
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(negedge clk);
  endtask

  task automatic write_table_size(input logic [SizeW-1:0] size);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(negedge clk);
    cfg_we <= 1'b0;
    table_size_q = size;
  endtask

  // Half inserts of random keys; the rest mostly deletes of keys that are live in the visible
  // slots, with some deletes of arbitrary keys mixed in.
  task automatic send_random_item();
    int unsigned     size;
    int unsigned     start;
    int unsigned     s;
    int unsigned     i;
    int unsigned     pick;
    bit              found;
    logic [KeyW-1:0] k;
    action_t         act;
    outcome_t        unused;
    size = active_slots();
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 2) == 0) k = KeyW'($urandom());
    else k = KeyW'($urandom_range(0, 4 * size));
    act = ACT_INSERT;
    unused.status = ST_INSERTED;
    unused.slot = '0;
    if (pick >= 50) begin
      act = ACT_DELETE;
      if (pick < 85) begin
        start = $urandom_range(0, size - 1);
        found = 1'b0;
        for (i = 0; i < size && !found; i++) begin
          s = (start + i) % size;
          if (slot_used_q[s]) begin
            k = slot_key_q[s];
            found = 1'b1;
          end
        end
      end
    end
    send_item(act, k, {$urandom(), $urandom()}, 1'b0, unused);
  endtask

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
    end
  end

  initial begin
    outcome_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d slot %0d", $time,
                   rsp_ch.status, rsp_ch.slot);
          mismatch_count++;
        end else begin
          want = expected_outcomes.pop_front();
          if (rsp_ch.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status,
                     rsp_ch.status);
            mismatch_count++;
          end
          if (rsp_ch.slot !== want.slot) begin
            $display("%0t: slot mismatch: expected %0d, got %0d", $time, want.slot,
                     rsp_ch.slot);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    int       phase;
    int       sub;
    int       n;
    dir_row_t row;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_INSERT;
    req_ch.key = '0;
    req_ch.payload = '0;
    mismatch_count = 0;
    send_idle_pct = 28;
    rsp_idle_pct = 85;
    table_size_q = SizeReset;
    foreach (slot_used_q[i]) begin
      slot_used_q[i] = 1'b0;
      slot_key_q[i] = '0;
      slot_pay_q[i] = '0;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Full-size table from reset, then one slot, size zero, oversize values and a size
    // where quadratic probing cannot reach every slot.
    dir_rows.push_back(typed_row(ACT_INSERT, '0, '0, ST_INSERTED, 8'd0));
    dir_rows.push_back(typed_row(ACT_INSERT, '1, '1, ST_INSERTED, 8'd255));
    dir_rows.push_back(typed_row(ACT_DELETE, 31'd5, '0, ST_NOT_FOUND, 8'd0));
    dir_rows.push_back(typed_row(ACT_DELETE, '0, '1, ST_DELETED, 8'd0));
    dir_rows.push_back(typed_row(ACT_INSERT, 31'd256, 64'hA5A5_5A5A_0F0F_F0F0, ST_INSERTED,
                                 8'd0));
    dir_rows.push_back(pred_row(ACT_INSERT, 31'd512, 64'h1234_5678_9ABC_DEF0));
    dir_rows.push_back(pred_row(ACT_INSERT, 31'd768, 64'h0000_0001_8000_0000));
    dir_rows.push_back(pred_row(ACT_DELETE, 31'd512, '0));
    dir_rows.push_back(pred_row(ACT_INSERT, 31'd1024, 64'h5A5A_A5A5_F0F0_0F0F));
    dir_rows.push_back(typed_row(ACT_DELETE, '1, '0, ST_DELETED, 8'd255));
    dir_rows.push_back(size_row(9'd1));
    dir_rows.push_back(typed_row(ACT_INSERT, 31'd12345, '1, ST_FULL, 8'd0));
    dir_rows.push_back(typed_row(ACT_DELETE, 31'd777, '0, ST_NOT_FOUND, 8'd0));
    dir_rows.push_back(size_row(9'd0));
    dir_rows.push_back(typed_row(ACT_DELETE, 31'd256, '0, ST_DELETED, 8'd0));
    dir_rows.push_back(typed_row(ACT_INSERT, 31'd9, 64'h9, ST_INSERTED, 8'd0));
    dir_rows.push_back(typed_row(ACT_INSERT, 31'd10, 64'hA, ST_FULL, 8'd0));
    dir_rows.push_back(size_row(9'h1FF));
    dir_rows.push_back(pred_row(ACT_INSERT, 31'd9, 64'h99));
    dir_rows.push_back(pred_row(ACT_INSERT, 31'd9, 64'h999));
    dir_rows.push_back(pred_row(ACT_DELETE, 31'd9, '0));
    dir_rows.push_back(pred_row(ACT_DELETE, 31'd9, '0));
    dir_rows.push_back(pred_row(ACT_DELETE, 31'd9, '0));
    dir_rows.push_back(size_row(9'd3));
    dir_rows.push_back(pred_row(ACT_INSERT, 31'd3, 64'h3));
    dir_rows.push_back(pred_row(ACT_INSERT, 31'd2, 64'h2));
    dir_rows.push_back(size_row(9'd257));
    dir_rows.push_back(pred_row(ACT_DELETE, 31'd1024, '0));
    dir_rows.push_back(pred_row(ACT_DELETE, 31'd768, '0));

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_SIZE) write_table_size(row.size);
      else send_item(row.act, row.key, row.pay, row.typed, row.want);
    end

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 28;
          rsp_idle_pct = 85;
        end
        1: begin
          send_idle_pct = 85;
          rsp_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          rsp_idle_pct = 0;
        end
      endcase
      for (sub = 0; sub < 9; sub++) begin
        case ($urandom_range(0, 9))
          0: write_table_size(9'd256);
          1: write_table_size(SizeW'($urandom_range(257, 511)));
          2: write_table_size(9'd0);
          default: write_table_size(SizeW'($urandom_range(1, 24)));
        endcase
        for (n = 0; n < 50; n++) begin
          // Hold the sender back until the table has answered everything.
          if (sub == 0 && n == 25) drain_results();
          send_random_item();
        end
      end
    end

    drain_results();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
      $display("quadratic_probe_hash_table_top verification clean");
    end else begin
      $display("quadratic_probe_hash_table_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/qpht_pkg.sv
hw/rtl/qpht_req_if.sv
hw/rtl/qpht_rsp_if.sv
hw/rtl/qpht_ctrl.sv
hw/rtl/qpht_dp.sv
hw/rtl/quadratic_probe_hash_table_top.sv
tb/quadratic_probe_hash_table_top_tb.sv
